// ===== rtl/core/bsape_pkg.sv =====
// ----------------------------------------------------------------------------
// bsape_pkg
// Shared types, constants and arithmetic helpers for the box axis projection
// extent core.
// ----------------------------------------------------------------------------
package bsape_pkg;

	localparam int COORD_BITS = 21;
	localparam int FRAC_BITS  = 8;
	localparam int PACK_BITS  = 63;
	localparam int AXES       = 3;
	localparam int RT_STEPS   = 32;
	localparam int DIV_STEPS  = 17;
	localparam int UNIT_BITS  = 18;
	localparam int VEC_BITS   = 41;
	localparam int PROD_BITS  = 62;
	localparam int SUMSQ_BITS = 42;
	localparam longint unsigned EPS_LIM = (64'd1 << (2 * FRAC_BITS)) / 64'd1000000;
	localparam logic [DIV_STEPS-1:0] UNIT_ONE = DIV_STEPS'(65536);

	typedef enum logic [1:0] {
		CFG_AXIS  = 2'd0,
		CFG_PLANE = 2'd1
	} cfg_idx_t;

	typedef enum logic [1:0] {
		STATUS_FOUND = 2'd0,
		STATUS_DEGEN = 2'd1,
		STATUS_EMPTY = 2'd2
	} status_t;

	typedef struct packed {
		logic [PACK_BITS-1:0] box_low_xyz;
		logic [PACK_BITS-1:0] box_high_xyz;
		logic                 box_valid;
		logic [PACK_BITS-1:0] linear_row_x;
		logic [PACK_BITS-1:0] linear_row_y;
		logic [PACK_BITS-1:0] linear_row_z;
		logic [PACK_BITS-1:0] world_offset_xyz;
		logic                 last_box;
	} box_in_t;

	typedef struct packed {
		logic [1:0]         status;
		logic signed [31:0] extent_min;
		logic signed [31:0] extent_max;
		logic signed [31:0] plane_clearance;
		logic signed [31:0] plane_shift;
	} result_t;

	typedef enum logic [4:0] {
		ST_IDLE, ST_SQ, ST_SQACC, ST_RTINIT, ST_RT, ST_DINIT, ST_DIV, ST_DSTORE,
		ST_BOX, ST_V0, ST_V1, ST_V2, ST_B, ST_LO, ST_HI, ST_MM, ST_SUM, ST_UPD,
		ST_PP, ST_PPACC, ST_OUT
	} state_t;

	typedef enum logic [3:0] {
		MUL_NONE, MUL_SQ, MUL_V0, MUL_V1, MUL_V2, MUL_OFF, MUL_LO, MUL_HI, MUL_PP
	} mul_sel_t;

	typedef enum logic [3:0] {
		OP_NONE, OP_SQSUM, OP_RTINIT, OP_RTSTEP, OP_DINIT, OP_DSTEP, OP_DSTORE,
		OP_VSET, OP_VADD, OP_BASE, OP_LO, OP_MM, OP_SUM, OP_UPD, OP_PPACC, OP_OUT
	} dp_op_t;

	typedef struct packed {
		logic     load;
		mul_sel_t mul;
		dp_op_t   op;
		logic [1:0] comp;
	} dp_cmd_t;

	typedef struct packed {
		logic degenerate;
		logic axis_ok;
		logic box_valid;
		logic last_box;
	} dp_stat_t;

	function automatic logic signed [31:0] round_sat(input logic signed [63:0] v,
			input int unsigned sh);
		logic signed [63:0] t;
		logic signed [63:0] s;
		t = v + (64'sd1 <<< (sh - 1));
		s = t >>> sh;
		if (s > 64'sd2147483647)
			return 32'sh7fffffff;
		else if (s < -64'sd2147483648)
			return 32'sh80000000;
		else
			return s[31:0];
	endfunction

	function automatic logic signed [31:0] sat_diff(input logic signed [31:0] a,
			input logic signed [31:0] b);
		logic signed [32:0] d;
		d = 33'(a) - 33'(b);
		if (d > 33'sd2147483647)
			return 32'sh7fffffff;
		else if (d < -33'sd2147483648)
			return 32'sh80000000;
		else
			return d[31:0];
	endfunction

endpackage

// ===== rtl/core/bsape_ctrl.sv =====
// ----------------------------------------------------------------------------
// bsape_ctrl
// Sequencer: axis normalisation at batch start, per-box projection steps and
// result issue.
// ----------------------------------------------------------------------------
module bsape_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	output logic                busy,
	input  bsape_pkg::dp_stat_t stat,
	output bsape_pkg::dp_cmd_t  cmd
);

	bsape_pkg::state_t state_q, state_d;
	logic [4:0] cnt_q;
	logic [1:0] comp_q;
	logic       batch_open_q;
	logic       accept;

	assign busy   = (state_q != bsape_pkg::ST_IDLE);
	assign accept = start & ~busy;

	always_comb begin
		state_d = state_q;
		case (state_q)
			bsape_pkg::ST_IDLE: begin
				if (accept)
					state_d = batch_open_q ? bsape_pkg::ST_BOX : bsape_pkg::ST_SQ;
			end
			bsape_pkg::ST_SQ:     state_d = bsape_pkg::ST_SQACC;
			bsape_pkg::ST_SQACC:  state_d = bsape_pkg::ST_RTINIT;
			bsape_pkg::ST_RTINIT: begin
				state_d = stat.degenerate ? bsape_pkg::ST_BOX : bsape_pkg::ST_RT;
			end
			bsape_pkg::ST_RT: begin
				if (cnt_q == 5'(bsape_pkg::RT_STEPS - 1))
					state_d = bsape_pkg::ST_DINIT;
			end
			bsape_pkg::ST_DINIT:  state_d = bsape_pkg::ST_DIV;
			bsape_pkg::ST_DIV: begin
				if (cnt_q == 5'(bsape_pkg::DIV_STEPS - 1))
					state_d = bsape_pkg::ST_DSTORE;
			end
			bsape_pkg::ST_DSTORE: begin
				state_d = (comp_q == 2'(bsape_pkg::AXES - 1)) ? bsape_pkg::ST_BOX
					: bsape_pkg::ST_DINIT;
			end
			bsape_pkg::ST_BOX: begin
				if (stat.box_valid && stat.axis_ok)
					state_d = bsape_pkg::ST_V0;
				else if (stat.last_box)
					state_d = bsape_pkg::ST_PP;
				else
					state_d = bsape_pkg::ST_IDLE;
			end
			bsape_pkg::ST_V0:  state_d = bsape_pkg::ST_V1;
			bsape_pkg::ST_V1:  state_d = bsape_pkg::ST_V2;
			bsape_pkg::ST_V2:  state_d = bsape_pkg::ST_B;
			bsape_pkg::ST_B:   state_d = bsape_pkg::ST_LO;
			bsape_pkg::ST_LO:  state_d = bsape_pkg::ST_HI;
			bsape_pkg::ST_HI:  state_d = bsape_pkg::ST_MM;
			bsape_pkg::ST_MM:  state_d = bsape_pkg::ST_SUM;
			bsape_pkg::ST_SUM: state_d = bsape_pkg::ST_UPD;
			bsape_pkg::ST_UPD: begin
				state_d = stat.last_box ? bsape_pkg::ST_PP : bsape_pkg::ST_IDLE;
			end
			bsape_pkg::ST_PP:    state_d = bsape_pkg::ST_PPACC;
			bsape_pkg::ST_PPACC: state_d = bsape_pkg::ST_OUT;
			bsape_pkg::ST_OUT:   state_d = bsape_pkg::ST_IDLE;
			default:             state_d = bsape_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		cmd      = '0;
		cmd.mul  = bsape_pkg::MUL_NONE;
		cmd.op   = bsape_pkg::OP_NONE;
		cmd.comp = comp_q;
		cmd.load = accept;
		case (state_q)
			bsape_pkg::ST_SQ:     cmd.mul = bsape_pkg::MUL_SQ;
			bsape_pkg::ST_SQACC:  cmd.op  = bsape_pkg::OP_SQSUM;
			bsape_pkg::ST_RTINIT: cmd.op  = bsape_pkg::OP_RTINIT;
			bsape_pkg::ST_RT:     cmd.op  = bsape_pkg::OP_RTSTEP;
			bsape_pkg::ST_DINIT:  cmd.op  = bsape_pkg::OP_DINIT;
			bsape_pkg::ST_DIV:    cmd.op  = bsape_pkg::OP_DSTEP;
			bsape_pkg::ST_DSTORE: cmd.op  = bsape_pkg::OP_DSTORE;
			bsape_pkg::ST_V0:     cmd.mul = bsape_pkg::MUL_V0;
			bsape_pkg::ST_V1: begin
				cmd.mul = bsape_pkg::MUL_V1;
				cmd.op  = bsape_pkg::OP_VSET;
			end
			bsape_pkg::ST_V2: begin
				cmd.mul = bsape_pkg::MUL_V2;
				cmd.op  = bsape_pkg::OP_VADD;
			end
			bsape_pkg::ST_B: begin
				cmd.mul = bsape_pkg::MUL_OFF;
				cmd.op  = bsape_pkg::OP_VADD;
			end
			bsape_pkg::ST_LO: begin
				cmd.mul = bsape_pkg::MUL_LO;
				cmd.op  = bsape_pkg::OP_BASE;
			end
			bsape_pkg::ST_HI: begin
				cmd.mul = bsape_pkg::MUL_HI;
				cmd.op  = bsape_pkg::OP_LO;
			end
			bsape_pkg::ST_MM:    cmd.op  = bsape_pkg::OP_MM;
			bsape_pkg::ST_SUM:   cmd.op  = bsape_pkg::OP_SUM;
			bsape_pkg::ST_UPD:   cmd.op  = bsape_pkg::OP_UPD;
			bsape_pkg::ST_PP:    cmd.mul = bsape_pkg::MUL_PP;
			bsape_pkg::ST_PPACC: cmd.op  = bsape_pkg::OP_PPACC;
			bsape_pkg::ST_OUT:   cmd.op  = bsape_pkg::OP_OUT;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= bsape_pkg::ST_IDLE;
			cnt_q        <= '0;
			comp_q       <= '0;
			batch_open_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (accept)
				batch_open_q <= 1'b1;
			else if (state_q == bsape_pkg::ST_OUT)
				batch_open_q <= 1'b0;
			case (state_q)
				bsape_pkg::ST_SQACC:  comp_q <= '0;
				bsape_pkg::ST_RTINIT: cnt_q  <= '0;
				bsape_pkg::ST_DINIT:  cnt_q  <= '0;
				bsape_pkg::ST_RT:     cnt_q  <= cnt_q + 5'd1;
				bsape_pkg::ST_DIV:    cnt_q  <= cnt_q + 5'd1;
				bsape_pkg::ST_DSTORE: comp_q <= comp_q + 2'd1;
				default: ;
			endcase
		end
	end

endmodule

// ===== rtl/core/bsape_dp.sv =====
// ----------------------------------------------------------------------------
// bsape_dp
// Datapath: three shared multiplier lanes, bit-serial square root and divider
// for the unit axis, corner min/max reduction and result register.
// ----------------------------------------------------------------------------
module bsape_dp (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_we,
	input  logic [1:0]          cfg_index,
	input  logic [62:0]         cfg_data,
	input  bsape_pkg::box_in_t  box,
	input  bsape_pkg::dp_cmd_t  cmd,
	output bsape_pkg::dp_stat_t stat,
	output logic                done,
	output bsape_pkg::result_t  result
);

	localparam int CB = bsape_pkg::COORD_BITS;
	localparam int UB = bsape_pkg::UNIT_BITS;
	localparam int VB = bsape_pkg::VEC_BITS;
	localparam int PB = bsape_pkg::PROD_BITS;
	localparam int QB = bsape_pkg::DIV_STEPS;

	logic [62:0] axis_q, plane_q;
	bsape_pkg::box_in_t box_q;

	logic signed [CB-1:0] ax [3];
	logic signed [CB-1:0] pp [3];
	logic signed [CB-1:0] lo [3];
	logic signed [CB-1:0] hi [3];
	logic signed [CB-1:0] off [3];
	logic signed [CB-1:0] mrow [3][3];

	logic signed [VB-1:0] ma [3];
	logic signed [CB-1:0] mb [3];
	logic signed [PB-1:0] prod_s1 [3];

	logic [bsape_pkg::SUMSQ_BITS-1:0] s_q;
	logic [62:0] rt_v_q, rt_res_q, rt_bit_q, rt_t;
	logic [30:0] root;
	logic [31:0] dv_rem_q, dv_r2;
	logic [QB-1:0] dv_low_q, dv_q, dv_u;
	logic [CB-1:0] mag;
	logic [46:0] dv_num;

	logic signed [UB-1:0] unit_q [3];
	logic signed [UB-1:0] u_mag;
	logic signed [VB-1:0] v_q [3];
	logic signed [63:0]   base_q, dmin_q, dmax_q;
	logic signed [PB-1:0] lo_q [3], mn_q [3], mx_q [3];
	logic signed [31:0]   pmin, pmax, ppq_q;
	logic signed [31:0]   run_min_q, run_max_q;
	logic                 any_found_q;
	bsape_pkg::result_t   res_d;

	always_comb begin
		for (int c = 0; c < 3; c++) begin
			ax[c]      = axis_q[c*CB +: CB];
			pp[c]      = plane_q[c*CB +: CB];
			lo[c]      = box_q.box_low_xyz[c*CB +: CB];
			hi[c]      = box_q.box_high_xyz[c*CB +: CB];
			off[c]     = box_q.world_offset_xyz[c*CB +: CB];
			mrow[0][c] = box_q.linear_row_x[c*CB +: CB];
			mrow[1][c] = box_q.linear_row_y[c*CB +: CB];
			mrow[2][c] = box_q.linear_row_z[c*CB +: CB];
		end
	end

	assign stat.degenerate = (64'(s_q) <= bsape_pkg::EPS_LIM);
	assign stat.axis_ok    = (unit_q[0] != '0) || (unit_q[1] != '0) || (unit_q[2] != '0);
	assign stat.box_valid  = box_q.box_valid;
	assign stat.last_box   = box_q.last_box;

	// operand select for the three lanes
	always_comb begin
		for (int c = 0; c < 3; c++) begin
			ma[c] = '0;
			mb[c] = '0;
			case (cmd.mul)
				bsape_pkg::MUL_SQ: begin
					ma[c] = VB'(ax[c]);
					mb[c] = ax[c];
				end
				bsape_pkg::MUL_V0: begin
					ma[c] = VB'(unit_q[0]);
					mb[c] = mrow[0][c];
				end
				bsape_pkg::MUL_V1: begin
					ma[c] = VB'(unit_q[1]);
					mb[c] = mrow[1][c];
				end
				bsape_pkg::MUL_V2: begin
					ma[c] = VB'(unit_q[2]);
					mb[c] = mrow[2][c];
				end
				bsape_pkg::MUL_OFF: begin
					ma[c] = VB'(unit_q[c]);
					mb[c] = off[c];
				end
				bsape_pkg::MUL_LO: begin
					ma[c] = v_q[c];
					mb[c] = lo[c];
				end
				bsape_pkg::MUL_HI: begin
					ma[c] = v_q[c];
					mb[c] = hi[c];
				end
				bsape_pkg::MUL_PP: begin
					ma[c] = VB'(unit_q[c]);
					mb[c] = pp[c];
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		for (int c = 0; c < 3; c++)
			prod_s1[c] <= PB'(ma[c] * mb[c]);
	end

	assign rt_t   = rt_res_q + rt_bit_q;
	assign root   = rt_res_q[30:0];
	assign mag    = ax[cmd.comp][CB-1] ? CB'(-ax[cmd.comp]) : CB'(ax[cmd.comp]);
	assign dv_num = {mag, 26'd0} + 47'(root >> 1);
	assign dv_r2  = {dv_rem_q[30:0], dv_low_q[QB-1]};
	assign dv_u   = (dv_q > bsape_pkg::UNIT_ONE) ? bsape_pkg::UNIT_ONE : dv_q;
	assign u_mag  = {1'b0, dv_u};
	assign pmin   = bsape_pkg::round_sat(dmin_q, 32);
	assign pmax   = bsape_pkg::round_sat(dmax_q, 32);

	always_comb begin
		res_d = '0;
		if (!stat.axis_ok)
			res_d.status = bsape_pkg::STATUS_DEGEN;
		else if (!any_found_q)
			res_d.status = bsape_pkg::STATUS_EMPTY;
		else begin
			res_d.status          = bsape_pkg::STATUS_FOUND;
			res_d.extent_min      = run_min_q;
			res_d.extent_max      = run_max_q;
			res_d.plane_clearance = bsape_pkg::sat_diff(run_min_q, ppq_q);
			res_d.plane_shift     = bsape_pkg::sat_diff(ppq_q, run_min_q);
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (cmd.load)
			box_q <= box;
		case (cmd.op)
			bsape_pkg::OP_SQSUM: begin
				s_q <= bsape_pkg::SUMSQ_BITS'(prod_s1[0] + prod_s1[1] + prod_s1[2]);
			end
			bsape_pkg::OP_RTINIT: begin
				rt_v_q   <= 63'({s_q, 20'd0});
				rt_res_q <= '0;
				rt_bit_q <= 63'd1 << 62;
			end
			bsape_pkg::OP_RTSTEP: begin
				if (rt_v_q >= rt_t) begin
					rt_v_q   <= rt_v_q - rt_t;
					rt_res_q <= (rt_res_q >> 1) + rt_bit_q;
				end else begin
					rt_res_q <= rt_res_q >> 1;
				end
				rt_bit_q <= rt_bit_q >> 2;
			end
			bsape_pkg::OP_DINIT: begin
				dv_rem_q <= 32'(dv_num[46:QB]);
				dv_low_q <= dv_num[QB-1:0];
				dv_q     <= '0;
			end
			bsape_pkg::OP_DSTEP: begin
				if (dv_r2 >= {1'b0, root}) begin
					dv_rem_q <= dv_r2 - {1'b0, root};
					dv_q     <= {dv_q[QB-2:0], 1'b1};
				end else begin
					dv_rem_q <= dv_r2;
					dv_q     <= {dv_q[QB-2:0], 1'b0};
				end
				dv_low_q <= dv_low_q << 1;
			end
			bsape_pkg::OP_VSET: begin
				for (int c = 0; c < 3; c++)
					v_q[c] <= VB'(prod_s1[c]);
			end
			bsape_pkg::OP_VADD: begin
				for (int c = 0; c < 3; c++)
					v_q[c] <= v_q[c] + VB'(prod_s1[c]);
			end
			bsape_pkg::OP_BASE: begin
				base_q <= (64'(prod_s1[0]) + 64'(prod_s1[1]) + 64'(prod_s1[2])) <<< 16;
			end
			bsape_pkg::OP_LO: begin
				for (int c = 0; c < 3; c++)
					lo_q[c] <= prod_s1[c];
			end
			bsape_pkg::OP_MM: begin
				for (int c = 0; c < 3; c++) begin
					mn_q[c] <= (lo_q[c] < prod_s1[c]) ? lo_q[c] : prod_s1[c];
					mx_q[c] <= (lo_q[c] > prod_s1[c]) ? lo_q[c] : prod_s1[c];
				end
			end
			bsape_pkg::OP_SUM: begin
				dmin_q <= base_q + 64'(mn_q[0]) + 64'(mn_q[1]) + 64'(mn_q[2]);
				dmax_q <= base_q + 64'(mx_q[0]) + 64'(mx_q[1]) + 64'(mx_q[2]);
			end
			bsape_pkg::OP_PPACC: begin
				ppq_q <= bsape_pkg::round_sat(64'(prod_s1[0]) + 64'(prod_s1[1])
					+ 64'(prod_s1[2]), 16);
			end
			default: ;
		endcase
	end

	// control state, configuration and result
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			axis_q      <= '0;
			plane_q     <= '0;
			unit_q[0]   <= '0;
			unit_q[1]   <= '0;
			unit_q[2]   <= '0;
			run_min_q   <= '0;
			run_max_q   <= '0;
			any_found_q <= 1'b0;
			done        <= 1'b0;
			result      <= '0;
		end else begin
			done <= (cmd.op == bsape_pkg::OP_OUT);
			if (cfg_we) begin
				case (cfg_index)
					bsape_pkg::CFG_AXIS:  axis_q  <= cfg_data;
					bsape_pkg::CFG_PLANE: plane_q <= cfg_data;
					default: ;
				endcase
			end
			case (cmd.op)
				bsape_pkg::OP_SQSUM: begin
					run_min_q   <= '0;
					run_max_q   <= '0;
					any_found_q <= 1'b0;
				end
				bsape_pkg::OP_RTINIT: begin
					for (int c = 0; c < 3; c++)
						unit_q[c] <= '0;
				end
				bsape_pkg::OP_DSTORE: begin
					unit_q[cmd.comp] <= ax[cmd.comp][CB-1] ? -u_mag : u_mag;
				end
				bsape_pkg::OP_UPD: begin
					any_found_q <= 1'b1;
					if (!any_found_q || (pmin < run_min_q))
						run_min_q <= pmin;
					if (!any_found_q || (pmax > run_max_q))
						run_max_q <= pmax;
				end
				bsape_pkg::OP_OUT: begin
					result      <= res_d;
					any_found_q <= 1'b0;
				end
				default: ;
			endcase
		end
	end

endmodule

// ===== rtl/core/box_set_axis_projection_extent_core.sv =====
// A valid box steps through BOX, V0, V1, V2, B, LO, HI, MM, SUM and UPD, a
// skipped box through BOX alone. The first box of a batch adds the axis
// normalisation (only SQ, SQACC and RTINIT for a degenerate axis): a 32-step
// square root and three 17-step divisions. The last box adds PP, PPACC and
// OUT; done pulses in the first cycle with busy low. Results cannot stall.
// Reset clears configuration, unit axis, running extent and the batch flag.
// ----------------------------------------------------------------------------
// box_set_axis_projection_extent_core
// Projects the world corners of a batch of oriented boxes onto a normalised
// axis and reports the extent and the clearance to a reference plane.
// ----------------------------------------------------------------------------
module box_set_axis_projection_extent_core (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  bsape_pkg::box_in_t box,
	output logic               done,
	output bsape_pkg::result_t result,
	input  logic               cfg_we,
	input  logic [1:0]         cfg_index,
	input  logic [62:0]        cfg_data
);

	bsape_pkg::dp_cmd_t  cmd;
	bsape_pkg::dp_stat_t stat;

	bsape_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.stat   (stat),
		.cmd    (cmd)
	);

	bsape_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.box       (box),
		.cmd       (cmd),
		.stat      (stat),
		.done      (done),
		.result    (result)
	);

endmodule
